FILE: src/mcbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcbp_pkg
// Shared types and constants for the MSB-first code bit packer.
// ----------------------------------------------------------------------------
package mcbp_pkg;

    // Fixed field widths
    localparam int BYTE_BITS  = 8;
    localparam int CODE_BITS  = 16;
    localparam int WIDTH_BITS = 5;
    localparam int HELD_W     = 7;
    localparam int HELD_CNT_W = 3;

    // Request modes
    localparam logic MODE_APPEND = 1'b0;
    localparam logic MODE_FLUSH  = 1'b1;

    // Input request
    typedef struct packed {
        logic                  mode;
        logic [WIDTH_BITS-1:0] width_bits;
        logic [CODE_BITS-1:0]  code_value;
    } in_item_t;

    // Result byte
    typedef struct packed {
        logic [BYTE_BITS-1:0] out_byte;
        logic                 last;
    } out_item_t;

    // Work handed from front to back: one or two completed bytes
    typedef struct packed {
        logic [BYTE_BITS-1:0] byte0;
        logic [BYTE_BITS-1:0] byte1;
        logic                 two;
    } job_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

FILE: src/mcbp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcbp_front
// Accepts requests, merges codes into the held bits or flushes them, and
// extracts the completed bytes as a job for the back end.
// ----------------------------------------------------------------------------
module mcbp_front #(
    parameter int MAX_CODE_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  mcbp_pkg::in_item_t   s_data,
    input  mcbp_pkg::queue_stat_t q_stat,
    output logic                 q_push,
    output mcbp_pkg::job_t       q_job
);
    import mcbp_pkg::*;

    localparam int LIM   = (MAX_CODE_BITS < CODE_BITS) ? MAX_CODE_BITS : CODE_BITS;
    localparam int ACC_W = LIM + HELD_W;
    localparam int N_W   = $clog2(ACC_W + BYTE_BITS + 1);

    logic [HELD_W-1:0]     held_bits_reg, held_bits_next;
    logic [HELD_CNT_W-1:0] held_count_reg, held_count_next;

    logic                  accept;
    logic [N_W-1:0]        w_sat;
    logic [ACC_W-1:0]      code_mask;
    logic [ACC_W-1:0]      acc;
    logic [N_W-1:0]        n_total;
    logic [2*HELD_W:0]     flush_wide;
    logic [HELD_W-1:0]     rem_mask;

    assign s_ready = !q_stat.full;
    assign accept  = s_valid && s_ready;

    // Saturate the width and build the merged accumulator
    always_comb begin
        if (s_data.width_bits > WIDTH_BITS'(LIM)) begin
            w_sat = N_W'(LIM);
        end else begin
            w_sat = N_W'(s_data.width_bits);
        end
        code_mask = ~({ACC_W{1'b1}} << w_sat);
        acc       = (ACC_W'(held_bits_reg) << w_sat) | (ACC_W'(s_data.code_value) & code_mask);
        n_total   = N_W'(held_count_reg) + w_sat;
        rem_mask  = ~({HELD_W{1'b1}} << n_total[HELD_CNT_W-1:0]);
        flush_wide = (2*HELD_W+1)'(held_bits_reg)
                     << (4'(BYTE_BITS) - {1'b0, held_count_reg});
    end

    // Classify the request and form the job
    always_comb begin
        held_bits_next  = held_bits_reg;
        held_count_next = held_count_reg;
        q_push          = 1'b0;
        q_job.byte0     = BYTE_BITS'(acc >> (n_total - N_W'(BYTE_BITS)));
        q_job.byte1     = BYTE_BITS'(acc >> (n_total - N_W'(2 * BYTE_BITS)));
        q_job.two       = 1'b0;
        if (accept) begin
            if (s_data.mode == MODE_FLUSH) begin
                q_job.byte0 = flush_wide[BYTE_BITS-1:0];
                if (held_count_reg != '0) begin
                    q_push          = 1'b1;
                    held_bits_next  = '0;
                    held_count_next = '0;
                end
            end else begin
                q_push          = (n_total >= N_W'(BYTE_BITS));
                q_job.two       = (n_total >= N_W'(2 * BYTE_BITS));
                held_count_next = n_total[HELD_CNT_W-1:0];
                held_bits_next  = HELD_W'(acc) & rem_mask;
            end
        end
    end

    // Hold the leftover bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_bits_reg  <= '0;
            held_count_reg <= '0;
        end else begin
            held_bits_reg  <= held_bits_next;
            held_count_reg <= held_count_next;
        end
    end

endmodule

FILE: src/mcbp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcbp_queue
// Two-entry job queue between the front and back ends.
// ----------------------------------------------------------------------------
module mcbp_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  mcbp_pkg::job_t        push_job,
    input  logic                  pop,
    output mcbp_pkg::job_t        pop_job,
    output mcbp_pkg::queue_stat_t stat
);
    import mcbp_pkg::*;

    job_t       mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign stat.full  = (count_reg == 2'd2);
    assign stat.empty = (count_reg == 2'd0);
    assign pop_job    = mem[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the job
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule

FILE: src/mcbp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcbp_back
// Drains jobs and emits one byte per cycle while not stalled, through an output register.
// ----------------------------------------------------------------------------
module mcbp_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  mcbp_pkg::queue_stat_t q_stat,
    input  mcbp_pkg::job_t        q_job,
    output logic                  q_pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output mcbp_pkg::out_item_t   m_data
);
    import mcbp_pkg::*;

    logic                 m_valid_reg, m_valid_next;
    out_item_t            m_data_reg, m_data_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [BYTE_BITS-1:0] pend_byte_reg, pend_byte_next;
    logic                 load;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign load    = !m_valid_reg || m_ready;

    // Pick the next byte: pending second byte first, then a new job
    always_comb begin
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        pend_valid_next = pend_valid_reg;
        pend_byte_next  = pend_byte_reg;
        q_pop           = 1'b0;
        if (load) begin
            if (pend_valid_reg) begin
                m_valid_next         = 1'b1;
                m_data_next.out_byte = pend_byte_reg;
                m_data_next.last     = 1'b1;
                pend_valid_next      = 1'b0;
            end else if (!q_stat.empty) begin
                q_pop                = 1'b1;
                m_valid_next         = 1'b1;
                m_data_next.out_byte = q_job.byte0;
                m_data_next.last     = !q_job.two;
                pend_valid_next      = q_job.two;
                pend_byte_next       = q_job.byte1;
            end else begin
                m_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            m_valid_reg    <= m_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
        m_data_reg    <= m_data_next;
        pend_byte_reg <= pend_byte_next;
    end

endmodule

FILE: src/msb_first_code_bit_packer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msb_first_code_bit_packer
// Packs variable-width codes into bytes, most significant bit first.
// ----------------------------------------------------------------------------
// Each request appends a code of 0 to 16 bits (widths above the limit are
// saturated, code bits above the width are dropped) or flushes the held bits
// as one zero-padded byte. The front end takes a request whenever its
// two-entry job queue has room and updates the held bits at once; the back
// end emits one byte per cycle, unless the output stalls, through an output
// register, so a request that completes two bytes occupies the output for
// both bytes in turn and one that completes none sends nothing. Throughput
// is one output byte per cycle when unstalled, set by the back end's single
// output register; the first byte of a request passes through the job queue
// and then the output register. The last byte of a request carries last high.
// ----------------------------------------------------------------------------
module msb_first_code_bit_packer #(
    parameter int MAX_CODE_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mcbp_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output mcbp_pkg::out_item_t m_data
);
    import mcbp_pkg::*;

    queue_stat_t q_stat;
    logic        q_push;
    logic        q_pop;
    job_t        push_job;
    job_t        pop_job;

    mcbp_front #(
        .MAX_CODE_BITS(MAX_CODE_BITS)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_stat  (q_stat),
        .q_push  (q_push),
        .q_job   (push_job)
    );

    mcbp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .pop_job  (pop_job),
        .stat     (q_stat)
    );

    mcbp_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_stat  (q_stat),
        .q_job   (pop_job),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // A stalled result holds its byte
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Never push into a full queue
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_stat.full)
        else $error("job queue overflow");

    // Never pop an empty queue
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_stat.empty)
        else $error("job queue underflow");

    // The second byte of a request follows its first without a gap
    a_pair_back_to_back: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.last |=> m_valid && m_data.last)
        else $error("second byte of a request did not follow");

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the MSB-first code bit packer.
// ----------------------------------------------------------------------------
// A driver pulls requests from a queue in bursts with random gaps. On every
// accepted request it updates a local copy of the held bits and appends the
// bytes that request should produce to a queue of expected bytes. A monitor
// checks each accepted output byte against that queue, field by field, while
// the output side stalls on patterns of its own. The stimulus starts with
// hand-picked corner cases. After that come mostly LZW-like runs of growing
// code widths, most closed by a flush, mixed with unconstrained noise requests.
// ----------------------------------------------------------------------------
module tb;
    import mcbp_pkg::*;

    localparam int PACK_MAX_BITS = 16;
    localparam int CODE_LIMIT    = (PACK_MAX_BITS < CODE_BITS) ? PACK_MAX_BITS : CODE_BITS;
    localparam int NUM_RANDOM    = 1650;
    localparam int REPORT_LIMIT  = 10;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    // Requests waiting to be driven, bytes waiting to be seen
    in_item_t  pending_reqs[$];
    out_item_t expected_bytes[$];

    // Local copy of the packer state
    logic [HELD_W-1:0]     model_held;
    logic [HELD_CNT_W-1:0] model_count;

    int unsigned fault_count   = 0;
    int unsigned bytes_checked = 0;
    int unsigned codes_taken   = 0;
    int unsigned flushes_taken = 0;
    int unsigned double_reqs   = 0;
    int unsigned silent_reqs   = 0;

    msb_first_code_bit_packer #(
        .MAX_CODE_BITS(PACK_MAX_BITS)
    ) uut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    always #10 aclk = ~aclk;

    // Work out the bytes one request completes and advance the held bits
    function automatic void pack_request(in_item_t req);
        int unsigned w;
        int unsigned n;
        int unsigned k;
        logic [31:0] acc;
        logic [7:0]  done_byte[2];
        out_item_t   res;
        k = 0;
        if (req.mode == MODE_FLUSH) begin
            if (model_count != 0) begin
                res.out_byte = 8'({model_held, 1'b0} << (HELD_W - model_count));
                res.last     = 1'b1;
                expected_bytes.push_back(res);
                flushes_taken++;
                model_held  = '0;
                model_count = '0;
            end else begin
                silent_reqs++;
            end
            return;
        end
        w = req.width_bits;
        if (w > CODE_LIMIT) w = CODE_LIMIT;
        acc = (32'(model_held) << w) | (32'(req.code_value) & ((32'h1 << w) - 1));
        n   = model_count + w;
        while (n >= BYTE_BITS && k < 2) begin
            n            = n - BYTE_BITS;
            done_byte[k] = 8'(acc >> n);
            k++;
        end
        for (int i = 0; i < k; i++) begin
            res.out_byte = done_byte[i];
            res.last     = (i == k - 1);
            expected_bytes.push_back(res);
        end
        codes_taken++;
        if (k == 2) double_reqs++;
        if (k == 0) silent_reqs++;
        model_count = HELD_CNT_W'(n);
        model_held  = HELD_W'(acc & ((32'h1 << n) - 1));
    endfunction

    // Log a mismatch; only the first few are printed
    task automatic report_fault(string what, out_item_t want, out_item_t got);
        fault_count++;
        if (fault_count <= REPORT_LIMIT) begin
            $display("%0t: %s: expected byte %02h last %0b, got byte %02h last %0b",
                     $time, what, want.out_byte, want.last, got.out_byte, got.last);
        end
    endtask

    // Driver: present requests in bursts, predict on each handshake
    int unsigned burst_left;
    int unsigned gap_left;

    always @(posedge aclk) begin : driver
        logic free;
        if (!aresetn) begin
            s_valid     <= 1'b0;
            model_held  = '0;
            model_count = '0;
            burst_left  = $urandom_range(1, 20);
            gap_left    = 0;
        end else begin
            free = !s_valid || s_ready;
            if (s_valid && s_ready) pack_request(s_data);
            if (free) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    s_data  <= pending_reqs.pop_front();
                    s_valid <= 1'b1;
                    burst_left--;
                    if (burst_left == 0) begin
                        // Pick the next burst; sometimes a long stretch with no gaps
                        if ($urandom_range(0, 7) == 0) begin
                            burst_left = $urandom_range(60, 160);
                            gap_left   = 0;
                        end else begin
                            burst_left = $urandom_range(1, 24);
                            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                        end
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall on a rotating pattern that changes now and then
    logic [7:0]  stall_pattern;
    logic [2:0]  pattern_pos;
    int unsigned pattern_left;

    always @(posedge aclk) begin : receiver
        if (!aresetn) begin
            m_ready       <= 1'b0;
            stall_pattern = 8'hFF;
            pattern_pos   = '0;
            pattern_left  = 0;
        end else begin
            if (pattern_left == 0) begin
                case ($urandom_range(0, 3))
                    0:       stall_pattern = 8'hFF;
                    1:       stall_pattern = 8'h01;
                    default: stall_pattern = 8'($urandom());
                endcase
                if (stall_pattern == 8'h00) stall_pattern = 8'h10;
                pattern_left = $urandom_range(16, 96);
            end
            pattern_left--;
            m_ready     <= stall_pattern[pattern_pos];
            pattern_pos = pattern_pos + 3'd1;
        end
    end

    // Monitor: compare each accepted byte with the oldest expected one
    always @(posedge aclk) begin : monitor
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            bytes_checked++;
            if (expected_bytes.size() == 0) begin
                want = '0;
                report_fault("unexpected byte", want, m_data);
            end else begin
                want = expected_bytes.pop_front();
                if (m_data.out_byte !== want.out_byte) report_fault("byte mismatch", want, m_data);
                if (m_data.last !== want.last) report_fault("last mismatch", want, m_data);
            end
        end
    end

    // Build append and flush requests
    function automatic in_item_t append_req(int unsigned w, int unsigned code);
        in_item_t req;
        req.mode       = MODE_APPEND;
        req.width_bits = WIDTH_BITS'(w);
        req.code_value = CODE_BITS'(code);
        return req;
    endfunction

    function automatic in_item_t flush_req();
        in_item_t req;
        req.mode       = MODE_FLUSH;
        req.width_bits = WIDTH_BITS'($urandom());
        req.code_value = CODE_BITS'($urandom());
        return req;
    endfunction

    initial begin : stimulus
        int unsigned  counted;
        int unsigned  gen_held;
        int unsigned  run_len;
        int unsigned  cur_w;
        int unsigned  w;
        in_item_t     req;
        int unsigned  guard;

        // Directed corners: flush with nothing held, zero width, saturation,
        // code wider than width, two-byte requests, flush with bits held
        pending_reqs.push_back(flush_req());
        pending_reqs.push_back(append_req(0, 16'hFFFF));
        pending_reqs.push_back(append_req(1, 16'h0001));
        pending_reqs.push_back(append_req(7, 16'h0055));
        pending_reqs.push_back(append_req(8, 16'h00A5));
        pending_reqs.push_back(append_req(16, 16'hFFFF));
        pending_reqs.push_back(append_req(16, 16'h0000));
        pending_reqs.push_back(append_req(3, 16'hFFFF));
        pending_reqs.push_back(append_req(16, 16'h8001));
        pending_reqs.push_back(flush_req());
        pending_reqs.push_back(flush_req());
        pending_reqs.push_back(append_req(7, 16'h007F));
        pending_reqs.push_back(append_req(16, 16'hC3A5));
        pending_reqs.push_back(append_req(31, 16'hFFFF));
        pending_reqs.push_back(append_req(17, 16'h0001));
        pending_reqs.push_back(append_req(5, 16'hFFE0));
        pending_reqs.push_back(append_req(0, 16'h1234));
        pending_reqs.push_back(append_req(24, 16'hAAAA));
        pending_reqs.push_back(append_req(9, 16'h01FF));
        pending_reqs.push_back(flush_req());
        pending_reqs.push_back(append_req(2, 16'h0002));
        pending_reqs.push_back(flush_req());

        // Random part: LZW-like runs with widths that grow, plus noise
        counted  = 0;
        gen_held = 0;
        while (counted < NUM_RANDOM) begin
            if ($urandom_range(0, 4) != 0) begin
                run_len = $urandom_range(3, 40);
                cur_w   = $urandom_range(9, 12);
                for (int i = 0; i < run_len; i++) begin
                    if (cur_w < 16 && $urandom_range(0, 5) == 0) cur_w++;
                    pending_reqs.push_back(append_req(cur_w, $urandom() & ((1 << cur_w) - 1)));
                    gen_held = (gen_held + cur_w) % 8;
                    counted++;
                end
                if ($urandom_range(0, 3) != 0) begin
                    pending_reqs.push_back(flush_req());
                    if (gen_held != 0) counted++;
                    gen_held = 0;
                end
            end else begin
                // Noise: any mode, any width including zero and oversized
                if ($urandom_range(0, 5) == 0) begin
                    req = flush_req();
                    if (gen_held != 0) counted++;
                    gen_held = 0;
                end else begin
                    case ($urandom_range(0, 3))
                        0:       w = $urandom_range(0, 31);
                        1:       w = $urandom_range(1, 8);
                        default: w = $urandom_range(9, 16);
                    endcase
                    case ($urandom_range(0, 5))
                        0:       req = append_req(w, 16'h0000);
                        1:       req = append_req(w, 16'hFFFF);
                        default: req = append_req(w, $urandom());
                    endcase
                    if (w != 0) counted++;
                    gen_held = (gen_held + ((w > CODE_LIMIT) ? CODE_LIMIT : w)) % 8;
                end
                pending_reqs.push_back(req);
            end
        end

        // Hold reset, then release it
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait for every request to go in, then for every byte to come out
        @(negedge aclk);
        while (pending_reqs.size() > 0 || s_valid) @(negedge aclk);
        guard = 0;
        while (expected_bytes.size() > 0 && guard < 100000) begin
            @(negedge aclk);
            guard++;
        end
        repeat (20) @(negedge aclk);
        if (expected_bytes.size() > 0) begin
            $display("%0d expected bytes never arrived", expected_bytes.size());
            fault_count += expected_bytes.size();
        end

        $display("Packed %0d codes and %0d padded flushes into %0d checked bytes;",
                 codes_taken, flushes_taken, bytes_checked);
        $display("%0d requests filled two bytes, %0d produced none.", double_reqs, silent_reqs);
        if (fault_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #10_000_000;
        $display("Run timed out");
        $display("tb: failure");
        $finish;
    end

endmodule

FILE: msb_first_code_bit_packer.f
src/mcbp_pkg.sv
src/mcbp_front.sv
src/mcbp_queue.sv
src/mcbp_back.sv
src/msb_first_code_bit_packer.sv
dv/tb.sv
